// ===== rtl/core/tccw_pkg.sv =====
package tccw_pkg;

    localparam int COLUMNS = 76;
    localparam int ROWS    = 23;
    localparam int CELLS   = ROWS * COLUMNS;

    localparam int CMD_W   = 2;
    localparam int CHAR_W  = 8;
    localparam int COLOR_W = 32;
    localparam int ROW_W   = 5;
    localparam int COL_W   = 7;
    localparam int ADDR_W  = $clog2(CELLS);

    localparam int PADDR_W   = 3;
    localparam int REG_IDX_W = PADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_DEFAULT_ROW_COLOR = '0;

    localparam logic [COLOR_W-1:0] DEFAULT_COLOR_RESET = 32'hFFE8_EEF7;

    localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0] CH_SPACE     = 8'd32;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [2:0] {
        OP_PUT,
        OP_NEWLINE,
        OP_BACKSPACE,
        OP_CLEAR,
        OP_READ,
        OP_NOP
    } op_t;

    typedef struct packed {
        op_t                op;
        logic [CHAR_W-1:0]  char_code;
        logic [COLOR_W-1:0] color;
        logic [ROW_W-1:0]   read_row;
        logic [COL_W-1:0]   read_col;
        logic               read_ok;
    } work_item_t;

    typedef struct packed {
        logic pop;
        logic init_busy;
    } back_ctrl_t;

    // logical row + scroll offset, both below ROWS
    function automatic logic [ROW_W-1:0] row_wrap(input logic [ROW_W:0] sum);
        logic [ROW_W:0] adj;
        adj = sum - (ROW_W + 1)'(ROWS);
        if (sum >= (ROW_W + 1)'(ROWS))
            return adj[ROW_W-1:0];
        else
            return sum[ROW_W-1:0];
    endfunction

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                    input logic [COL_W-1:0] col);
        return ADDR_W'(row) * ADDR_W'(COLUMNS) + ADDR_W'(col);
    endfunction

endpackage

// ===== rtl/core/tccw_ram.sv =====
module tccw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/tccw_front.sv =====
module tccw_front
    import tccw_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [CMD_W-1:0]    cmd,
    input  logic [CHAR_W-1:0]   char_code,
    input  logic [COLOR_W-1:0]  color,
    input  logic [ROW_W-1:0]    read_row,
    input  logic [COL_W-1:0]    read_col,
    input  back_ctrl_t          ctrl,
    output logic                q_valid,
    output work_item_t          q_item
);

    work_item_t        item;
    work_item_t        entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              push;

    always_comb
    begin
        item.char_code = char_code;
        item.color     = color;
        item.read_row  = read_row;
        item.read_col  = read_col;
        item.read_ok   = (read_row < ROW_W'(ROWS)) && (read_col < COL_W'(COLUMNS));
        unique case (cmd)
            CMD_PUT:
            begin
                if (char_code == CH_NEWLINE)
                    item.op = OP_NEWLINE;
                else if (char_code == CH_BACKSPACE)
                    item.op = OP_BACKSPACE;
                else
                    item.op = OP_PUT;
            end
            CMD_CLEAR: item.op = OP_CLEAR;
            CMD_READ:  item.op = OP_READ;
            default:   item.op = OP_NOP;
        endcase
    end

    assign in_ready = (count_reg != QCNT_W'(QUEUE_DEPTH)) && !ctrl.init_busy;
    assign push     = in_valid && in_ready;
    assign q_valid  = (count_reg != '0);
    assign q_item   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (ctrl.pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !ctrl.pop)
            count_next = count_reg + 1'b1;
        else if (!push && ctrl.pop)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= item;
    end

endmodule

// ===== rtl/core/tccw_back.sv =====
module tccw_back
    import tccw_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [COLOR_W-1:0]  default_color,
    input  logic                q_valid,
    input  work_item_t          q_item,
    output back_ctrl_t          ctrl,
    output logic                ram_we,
    output logic [ADDR_W-1:0]   ram_waddr,
    output logic [CHAR_W-1:0]   ram_wdata,
    output logic                ram_re,
    output logic [ADDR_W-1:0]   ram_raddr,
    input  logic [CHAR_W-1:0]   ram_rdata,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [ROW_W-1:0]    cursor_row,
    output logic [COL_W-1:0]    cursor_col,
    output logic                scrolled,
    output logic [CHAR_W-1:0]   cell_char,
    output logic [COLOR_W-1:0]  cell_row_color
);

    typedef enum logic [1:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_READ
    } state_t;

    state_t             state_reg, state_next;
    logic [ROW_W-1:0]   top_reg, top_next;
    logic [ROW_W-1:0]   cur_row_reg, cur_row_next;
    logic [COL_W-1:0]   cur_col_reg, cur_col_next;
    logic [ADDR_W-1:0]  sweep_addr_reg, sweep_addr_next;
    logic [ADDR_W-1:0]  sweep_last_reg, sweep_last_next;
    logic               init_busy_reg, init_busy_next;
    logic [COLOR_W-1:0] color_hold_reg, color_hold_next;
    logic               out_valid_reg, out_valid_next;
    logic [ROW_W-1:0]   out_row_reg, out_row_next;
    logic [COL_W-1:0]   out_col_reg, out_col_next;
    logic               out_scrolled_reg, out_scrolled_next;
    logic [CHAR_W-1:0]  out_char_reg, out_char_next;
    logic [COLOR_W-1:0] out_color_reg, out_color_next;

    logic [COLOR_W-1:0] row_color_reg [ROWS];

    logic              slot_free;
    logic              q_pop;
    logic              emit;
    logic              wrap_row;
    logic              did_scroll;
    logic              color_we;
    logic              scroll_we;
    logic              clear_colors;
    logic [ROW_W-1:0]  cur_phys;
    logic [ROW_W-1:0]  rd_phys;
    logic [ROW_W-1:0]  top_inc;
    logic [ADDR_W-1:0] cur_addr;
    logic [ADDR_W-1:0] bs_addr;
    logic [ADDR_W-1:0] row_base;

    assign cur_phys = row_wrap({1'b0, cur_row_reg} + {1'b0, top_reg});
    assign rd_phys  = row_wrap({1'b0, q_item.read_row} + {1'b0, top_reg});
    assign top_inc  = row_wrap({1'b0, top_reg} + (ROW_W + 1)'(1));
    assign cur_addr = cell_addr(cur_phys, cur_col_reg);
    assign bs_addr  = cell_addr(cur_phys, cur_col_reg - COL_W'(1));
    // the top physical row becomes the new bottom row on a scroll
    assign row_base = cell_addr(top_reg, '0);

    assign slot_free = !out_valid_reg || out_ready;
    assign ctrl      = '{pop: q_pop, init_busy: init_busy_reg};

    always_comb
    begin
        state_next        = state_reg;
        top_next          = top_reg;
        cur_row_next      = cur_row_reg;
        cur_col_next      = cur_col_reg;
        sweep_addr_next   = sweep_addr_reg;
        sweep_last_next   = sweep_last_reg;
        init_busy_next    = init_busy_reg;
        color_hold_next   = color_hold_reg;
        out_valid_next    = out_valid_reg;
        out_row_next      = out_row_reg;
        out_col_next      = out_col_reg;
        out_scrolled_next = out_scrolled_reg;
        out_char_next     = out_char_reg;
        out_color_next    = out_color_reg;
        q_pop             = 1'b0;
        emit              = 1'b0;
        wrap_row          = 1'b0;
        did_scroll        = 1'b0;
        color_we          = 1'b0;
        scroll_we         = 1'b0;
        clear_colors      = 1'b0;
        ram_we            = 1'b0;
        ram_waddr         = cur_addr;
        ram_wdata         = q_item.char_code;
        ram_re            = 1'b0;
        ram_raddr         = cell_addr(rd_phys, q_item.read_col);

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_SWEEP:
            begin
                ram_we    = 1'b1;
                ram_waddr = sweep_addr_reg;
                ram_wdata = '0;
                if (sweep_addr_reg == sweep_last_reg)
                begin
                    state_next     = ST_IDLE;
                    init_busy_next = 1'b0;
                end
                else
                    sweep_addr_next = sweep_addr_reg + 1'b1;
            end
            ST_IDLE:
            begin
                if (q_valid && slot_free)
                begin
                    q_pop = 1'b1;
                    emit  = 1'b1;
                    unique case (q_item.op)
                        OP_PUT:
                        begin
                            ram_we   = 1'b1;
                            color_we = 1'b1;
                            if (cur_col_reg == COL_W'(COLUMNS - 1))
                                wrap_row = 1'b1;
                            else
                                cur_col_next = cur_col_reg + 1'b1;
                        end
                        OP_NEWLINE:
                        begin
                            color_we = 1'b1;
                            wrap_row = 1'b1;
                        end
                        OP_BACKSPACE:
                        begin
                            if (cur_col_reg != '0)
                            begin
                                cur_col_next = cur_col_reg - 1'b1;
                                ram_we       = 1'b1;
                                ram_waddr    = bs_addr;
                                ram_wdata    = CH_SPACE;
                            end
                        end
                        OP_CLEAR:
                        begin
                            clear_colors    = 1'b1;
                            top_next        = '0;
                            cur_row_next    = '0;
                            cur_col_next    = '0;
                            sweep_addr_next = '0;
                            sweep_last_next = ADDR_W'(CELLS - 1);
                            state_next      = ST_SWEEP;
                        end
                        OP_READ:
                        begin
                            if (q_item.read_ok)
                            begin
                                ram_re          = 1'b1;
                                color_hold_next = row_color_reg[rd_phys];
                                emit            = 1'b0;
                                state_next      = ST_READ;
                            end
                        end
                        default:
                        begin
                        end
                    endcase

                    if (wrap_row)
                    begin
                        cur_col_next = '0;
                        if (cur_row_reg == ROW_W'(ROWS - 1))
                        begin
                            did_scroll      = 1'b1;
                            scroll_we       = 1'b1;
                            top_next        = top_inc;
                            sweep_addr_next = row_base;
                            sweep_last_next = row_base + ADDR_W'(COLUMNS - 1);
                            state_next      = ST_SWEEP;
                        end
                        else
                            cur_row_next = cur_row_reg + 1'b1;
                    end

                    if (emit)
                    begin
                        out_valid_next    = 1'b1;
                        out_row_next      = cur_row_next;
                        out_col_next      = cur_col_next;
                        out_scrolled_next = did_scroll;
                        out_char_next     = '0;
                        out_color_next    = '0;
                    end
                end
            end
            ST_READ:
            begin
                if (slot_free)
                begin
                    out_valid_next    = 1'b1;
                    out_row_next      = cur_row_reg;
                    out_col_next      = cur_col_reg;
                    out_scrolled_next = 1'b0;
                    out_char_next     = ram_rdata;
                    out_color_next    = color_hold_reg;
                    state_next        = ST_IDLE;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_SWEEP;
            top_reg          <= '0;
            cur_row_reg      <= '0;
            cur_col_reg      <= '0;
            sweep_addr_reg   <= '0;
            sweep_last_reg   <= ADDR_W'(CELLS - 1);
            init_busy_reg    <= 1'b1;
            color_hold_reg   <= '0;
            out_valid_reg    <= 1'b0;
            out_row_reg      <= '0;
            out_col_reg      <= '0;
            out_scrolled_reg <= 1'b0;
            out_char_reg     <= '0;
            out_color_reg    <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            top_reg          <= top_next;
            cur_row_reg      <= cur_row_next;
            cur_col_reg      <= cur_col_next;
            sweep_addr_reg   <= sweep_addr_next;
            sweep_last_reg   <= sweep_last_next;
            init_busy_reg    <= init_busy_next;
            color_hold_reg   <= color_hold_next;
            out_valid_reg    <= out_valid_next;
            out_row_reg      <= out_row_next;
            out_col_reg      <= out_col_next;
            out_scrolled_reg <= out_scrolled_next;
            out_char_reg     <= out_char_next;
            out_color_reg    <= out_color_next;
        end
    end

    // a newline or a wrapping put on the bottom row writes the cursor row and sets the old top row to default_color
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ROWS; i++)
                row_color_reg[i] <= DEFAULT_COLOR_RESET;
        end
        else if (clear_colors)
        begin
            for (int i = 0; i < ROWS; i++)
                row_color_reg[i] <= default_color;
        end
        else
        begin
            if (color_we)
                row_color_reg[cur_phys] <= q_item.color;
            if (scroll_we)
                row_color_reg[top_reg] <= default_color;
        end
    end

    assign out_valid      = out_valid_reg;
    assign cursor_row     = out_row_reg;
    assign cursor_col     = out_col_reg;
    assign scrolled       = out_scrolled_reg;
    assign cell_char      = out_char_reg;
    assign cell_row_color = out_color_reg;

endmodule

// ===== rtl/core/text_console_cell_writer.sv =====
// Text console cell writer: a 23 x 76 character store with cursor and per-row color.
// Command channel (in_valid/in_ready, cmd, char_code, color, read_row, read_col) takes
// put character, clear screen and read cell transactions; every transaction returns one
// result on the out_valid/out_ready channel (cursor, scrolled flag, read cell and color).
// A two-entry queue sits between the decoder and the executing state machine, and the
// result sits in an output register, so input keeps flowing while a result is stalled.
// An in-range read adds a registered character RAM read before its result.
// Throughput: one transaction per cycle for put, backspace, newline and unused codes
// while out_ready takes each result; a read holds the execution unit in ST_READ
// until its result is registered. A scroll adds a sweep that zeroes the new bottom
// row in RAM, a clear a sweep of the whole RAM, one cell per cycle through the
// single write port. Scrolling moves a row offset. Reset: cursor homes, row colors
// take 0xFFE8EEF7, and a clearing pass zeroes the character RAM; in_ready stays low
// until it ends. APB writes are taken at all times.
// When out_ready is low the result holds; up to two further transactions queue up
// before in_ready drops.
module text_console_cell_writer
    import tccw_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [CMD_W-1:0]    cmd,
    input  logic [CHAR_W-1:0]   char_code,
    input  logic [COLOR_W-1:0]  color,
    input  logic [ROW_W-1:0]    read_row,
    input  logic [COL_W-1:0]    read_col,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [ROW_W-1:0]    cursor_row,
    output logic [COL_W-1:0]    cursor_col,
    output logic                scrolled,
    output logic [CHAR_W-1:0]   cell_char,
    output logic [COLOR_W-1:0]  cell_row_color
);

    logic [COLOR_W-1:0] default_color_reg;
    logic               reg_hit;
    back_ctrl_t         ctrl;
    logic               q_valid;
    work_item_t         q_item;
    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    logic [CHAR_W-1:0]  ram_wdata;
    logic               ram_re;
    logic [ADDR_W-1:0]  ram_raddr;
    logic [CHAR_W-1:0]  ram_rdata;

    assign pready  = 1'b1;
    assign reg_hit = (paddr[PADDR_W-1:2] == REG_DEFAULT_ROW_COLOR);
    assign prdata  = reg_hit ? default_color_reg : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            default_color_reg <= DEFAULT_COLOR_RESET;
        else if (psel && penable && pwrite && pready && reg_hit)
            default_color_reg <= pwdata;
    end

    tccw_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .cmd       (cmd),
        .char_code (char_code),
        .color     (color),
        .read_row  (read_row),
        .read_col  (read_col),
        .ctrl      (ctrl),
        .q_valid   (q_valid),
        .q_item    (q_item)
    );

    tccw_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .default_color  (default_color_reg),
        .q_valid        (q_valid),
        .q_item         (q_item),
        .ctrl           (ctrl),
        .ram_we         (ram_we),
        .ram_waddr      (ram_waddr),
        .ram_wdata      (ram_wdata),
        .ram_re         (ram_re),
        .ram_raddr      (ram_raddr),
        .ram_rdata      (ram_rdata),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .cursor_row     (cursor_row),
        .cursor_col     (cursor_col),
        .scrolled       (scrolled),
        .cell_char      (cell_char),
        .cell_row_color (cell_row_color)
    );

    tccw_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (CELLS)
    ) u_cells (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule

// ===== rtl/core/tccw_checker.sv =====
module tccw_checker
    import tccw_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                out_valid,
    input  logic                out_ready,
    input  logic [ROW_W-1:0]    cursor_row,
    input  logic [COL_W-1:0]    cursor_col,
    input  logic                scrolled,
    input  logic [CHAR_W-1:0]   cell_char,
    input  logic [COLOR_W-1:0]  cell_row_color
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(cursor_row)
            && $stable(cursor_col) && $stable(scrolled) && $stable(cell_char)
            && $stable(cell_row_color))
        else $error("result changed while stalled");

    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (cursor_row < ROW_W'(ROWS)) && (cursor_col < COL_W'(COLUMNS)))
        else $error("cursor outside the screen");

    a_scroll_bottom: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && scrolled |-> (cursor_row == ROW_W'(ROWS - 1)) && (cursor_col == '0))
        else $error("scroll did not leave cursor at start of bottom row");

    a_scroll_no_cell: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && scrolled |-> (cell_char == '0) && (cell_row_color == '0))
        else $error("scrolling transaction reported cell data");

endmodule

bind text_console_cell_writer tccw_checker u_tccw_checker (.*);
